[hdl/can_bts_pkg.sv]
// Shared constants, types and helpers for the CAN bit timing search block.
`timescale 1ns / 1ps

package can_bts_pkg;

    localparam int MAX_QUANTA = 25;
    localparam int MIN_QUANTA = 8;

    localparam int CLK_W  = 28;
    localparam int RATE_W = 27;
    localparam int TQ_W   = 8;
    localparam int DEN_W  = RATE_W + TQ_W;
    localparam int PRE_W  = 10;
    localparam int SEG_W  = 7;
    localparam int CNT_W  = $clog2(CLK_W);

    localparam logic [CLK_W-1:0] CLOCK_RESET     = CLK_W'(80000000);
    localparam logic [CLK_W-1:0] PRESCALER_LIMIT = CLK_W'(1023);
    localparam logic [TQ_W-1:0]  SEGMENT_LIMIT   = TQ_W'(127);
    localparam logic [TQ_W-1:0]  TQ_MAX          = TQ_W'(MAX_QUANTA);
    localparam logic [TQ_W-1:0]  TQ_MIN          = TQ_W'(MIN_QUANTA);
    localparam logic             SEARCH_EMPTY    = (MAX_QUANTA < MIN_QUANTA);

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_ERR  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_DIV   = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic             start;
        logic [CLK_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [CLK_W-1:0] quotient;
        logic [CLK_W-1:0] remainder;
    } t_div_rsp;

    typedef struct packed {
        logic             status;
        logic [PRE_W-1:0] prescaler;
        logic [SEG_W-1:0] seg_before;
        logic [SEG_W-1:0] seg_after;
        logic             jump_width;
    } t_result;

    // floor(4*tq/5) as (4*tq*1639) >> 13, exact for tq below 256
    function automatic logic [TQ_W-1:0] f_sample(input logic [TQ_W-1:0] tq);
        logic [TQ_W+13:0] prod;
        prod = {12'b0, tq, 2'b00} * (TQ_W+14)'(1639);
        return prod[TQ_W+12:13];
    endfunction

endpackage

[hdl/can_bts_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module can_bts_div
    import can_bts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CLK_W-1:0] r_rem, n_rem;
    logic [CLK_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CLK_W:0]   w_trial;
    logic             w_fit;

    assign w_trial = {r_rem, r_quo[CLK_W-1]};
    assign w_fit   = ({{(DEN_W-CLK_W-1){1'b0}}, w_trial} >= r_den);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(CLK_W - 1);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[CLK_W-2:0], w_fit};
            if (w_fit) begin
                n_rem = CLK_W'(w_trial - r_den[CLK_W:0]);
            end else begin
                n_rem = w_trial[CLK_W-1:0];
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

[hdl/can_exact_bit_timing_search_core.sv]
// Top level of the CAN exact bit timing search: sequencer, candidate checks, output register.
//
//  channel  | direction | fields (low first)
//  ---------+-----------+---------------------------------------------------------
//  s_axis   | in        | tdata: bitrate[26:0], zero fill to 32
//  m_axis   | out       | tdata: prescaler[9:0], seg_before[6:0], seg_after[6:0],
//           |           | jump_width, zero fill to 32; tuser: status
//  cfg      | in        | clock frequency in Hz [27:0], no index
//
// Each candidate count goes through a multiply step, the shared divider (28 quotient
// bits) and a check. A request tries up to MAX - MIN + 1 candidate counts, 18 at the
// defaults, from the top down. Reset is synchronous and loads the clock frequency
// with 80000000. s_axis_tready is high only when idle; one finished result waits in
// the output register while the next request is taken.
`timescale 1ns / 1ps

module can_exact_bit_timing_search_core
    import can_bts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // bitrate[26:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // prescaler, seg_before, seg_after, jump_width
    output logic        m_axis_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [27:0] i_cfg_data     // clock frequency in Hz
);

    t_state            r_state, n_state;
    logic [CLK_W-1:0]  r_clk_hz;
    logic [RATE_W-1:0] r_rate, n_rate;
    logic [TQ_W-1:0]   r_tq, n_tq;
    logic [TQ_W-1:0]   r_sample, n_sample;
    t_result           r_res, n_res;
    t_result           r_out, n_out;
    logic              r_out_vld, n_out_vld;
    t_div_req          w_req;
    t_div_rsp          w_rsp;
    logic [RATE_W-1:0] w_in_rate;
    logic [TQ_W-1:0]   w_after;
    logic              w_hit;
    t_result           w_err;

    assign w_in_rate     = s_axis_tdata[RATE_W-1:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'b0, r_out.jump_width, r_out.seg_after, r_out.seg_before,
                            r_out.prescaler};
    assign m_axis_tuser  = r_out.status;

    assign w_err = '{status: STATUS_ERR, prescaler: '0, seg_before: '0,
                     seg_after: '0, jump_width: 1'b0};

    assign w_req.start    = (r_state == S_MUL);
    assign w_req.dividend = r_clk_hz;
    assign w_req.divisor  = DEN_W'(r_rate) * DEN_W'(r_tq);

    can_bts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_after = r_tq - r_sample;
    assign w_hit   = (w_rsp.remainder == '0) && (w_rsp.quotient != '0)
                  && (w_rsp.quotient <= PRESCALER_LIMIT)
                  && (r_sample >= TQ_W'(2)) && (r_sample < r_tq)
                  && (r_sample <= SEGMENT_LIMIT + TQ_W'(1))
                  && (w_after <= SEGMENT_LIMIT);

    always_comb begin
        n_state   = r_state;
        n_rate    = r_rate;
        n_tq      = r_tq;
        n_sample  = r_sample;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_rate = w_in_rate;
                    n_tq   = TQ_MAX;
                    if (w_in_rate == '0 || SEARCH_EMPTY) begin
                        n_res   = w_err;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_sample = f_sample(r_tq);
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_hit) begin
                    n_res = '{status: STATUS_GOOD,
                              prescaler: w_rsp.quotient[PRE_W-1:0],
                              seg_before: SEG_W'(r_sample - TQ_W'(1)),
                              seg_after: w_after[SEG_W-1:0],
                              jump_width: 1'b1};
                    n_state = S_DONE;
                end else if (r_tq == TQ_MIN) begin
                    n_res   = w_err;
                    n_state = S_DONE;
                end else begin
                    n_tq    = r_tq - TQ_W'(1);
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_clk_hz  <= CLOCK_RESET;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid) begin
                r_clk_hz <= i_cfg_data;
            end
        end
        r_rate   <= n_rate;
        r_tq     <= n_tq;
        r_sample <= n_sample;
        r_res    <= n_res;
        r_out    <= n_out;
    end

endmodule

[bench/tb.sv]
// Self-checking testbench for the CAN exact bit timing search core.
`timescale 1ns / 1ps

module tb;
    import can_bts_pkg::*;

    localparam int          TAIL_ITEMS   = 150;
    localparam int          SETTLE_TICKS = 600;
    localparam longint      CYCLE_LIMIT  = 5000000;
    localparam int unsigned BUS_RATES [13] = '{10000, 20000, 50000, 83333, 100000, 125000,
        250000, 500000, 800000, 1000000, 2000000, 5000000, 8000000};

    typedef struct {
        bit               is_clock;
        logic [CLK_W-1:0] value;
    } t_pending_req;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // bitrate[26:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // prescaler[9:0], seg_before[6:0], seg_after[6:0], jump_width
    logic        m_axis_tuser;         // status
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [27:0] i_cfg_data    = '0;   // clock frequency in Hz

    t_pending_req     pending_reqs[$];
    t_result          expected_timings[$];
    logic [CLK_W-1:0] model_clock_hz = CLOCK_RESET;
    logic             quiet = 1'b0;
    int               send_gap = 0;
    int               recv_stall = 0;
    int               failures = 0;
    longint           cycle_count = 0;

    can_exact_bit_timing_search_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // search quanta per bit from the top; first exact fit within limits wins
    function automatic t_result timing_for(input logic [RATE_W-1:0] rate,
                                           input logic [CLK_W-1:0] clk_hz);
        t_result         res;
        longint unsigned den;
        longint unsigned pre;
        longint unsigned sp;
        res = '0;
        res.status = STATUS_ERR;
        if (rate == 0) return res;
        for (int tq = MAX_QUANTA; tq >= MIN_QUANTA && tq > 0; tq--) begin
            den = 64'(rate) * 64'(tq);
            if (den == 0 || 64'(clk_hz) % den != 0) continue;
            pre = 64'(clk_hz) / den;
            sp  = 64'((tq * 4) / 5);
            if (pre < 1 || pre > 64'(PRESCALER_LIMIT) || sp <= 1 || sp >= 64'(tq)) continue;
            if (sp - 1 < 1 || sp - 1 > 64'(SEGMENT_LIMIT) ||
                64'(tq) - sp < 1 || 64'(tq) - sp > 64'(SEGMENT_LIMIT)) continue;
            res.status     = STATUS_GOOD;
            res.prescaler  = pre[PRE_W-1:0];
            res.seg_before = SEG_W'(sp - 1);
            res.seg_after  = SEG_W'(64'(tq) - sp);
            res.jump_width = 1'b1;
            return res;
        end
        return res;
    endfunction

    // favor rates that divide the clock exactly so the search finds real timings
    function automatic logic [RATE_W-1:0] pick_bitrate(input logic [CLK_W-1:0] clk_hz);
        int unsigned kind;
        int unsigned den;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            for (int k = 0; k < 32; k++) begin
                den = $urandom_range(MIN_QUANTA, MAX_QUANTA) *
                      (($urandom_range(0, 3) == 0) ? $urandom_range(1, 1100)
                                                   : $urandom_range(1, 40));
                if (clk_hz != 0 && 32'(clk_hz) % den == 0) return RATE_W'(32'(clk_hz) / den);
            end
        end
        if (kind < 60) return RATE_W'(BUS_RATES[$urandom_range(0, 12)]);
        if (kind < 65) return '0;
        if (kind < 80) return RATE_W'($urandom_range(1, 20000));
        return RATE_W'($urandom_range(0, 80000000));
    endfunction

    task automatic queue_bitrate(input int unsigned rate);
        pending_reqs.push_back('{is_clock: 1'b0, value: CLK_W'(rate)});
    endtask

    task automatic queue_clock(input int unsigned clk_hz);
        pending_reqs.push_back('{is_clock: 1'b1, value: CLK_W'(clk_hz)});
    endtask

    task automatic queue_random(input int unsigned clk_hz, input int count);
        for (int k = 0; k < count; k++) queue_bitrate(32'(pick_bitrate(CLK_W'(clk_hz))));
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_pending_req nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
            model_clock_hz = CLOCK_RESET;
            send_gap       = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_timings.push_back(timing_for(s_axis_tdata[RATE_W-1:0], model_clock_hz));
            if (i_cfg_valid && o_cfg_ready) model_clock_hz = i_cfg_data;
            quiet <= (pending_reqs.size() < TAIL_ITEMS);
            if ((!s_axis_tvalid || s_axis_tready) && (!i_cfg_valid || o_cfg_ready)) begin
                if (send_gap > 0 || pending_reqs.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_axis_tvalid <= 1'b0;
                    i_cfg_valid   <= 1'b0;
                end else if (pending_reqs[0].is_clock) begin
                    s_axis_tvalid <= 1'b0;
                    if (expected_timings.size() == 0) begin
                        nxt = pending_reqs.pop_front();
                        i_cfg_valid <= 1'b1;
                        i_cfg_data  <= nxt.value;
                    end else begin
                        i_cfg_valid <= 1'b0;
                    end
                end else begin
                    nxt = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'b0, nxt.value[RATE_W-1:0]};
                    i_cfg_valid   <= 1'b0;
                    if (!quiet && $urandom_range(0, 2) == 0) send_gap = $urandom_range(1, 14);
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_timings.size() == 0) begin
                    $error("result with none pending: tdata %h", m_axis_tdata);
                    failures++;
                end else begin
                    want = expected_timings.pop_front();
                    check_field("status", 32'(want.status), 32'(m_axis_tuser));
                    check_field("prescaler", 32'(want.prescaler), 32'(m_axis_tdata[9:0]));
                    check_field("segment_before_sample", 32'(want.seg_before),
                                32'(m_axis_tdata[16:10]));
                    check_field("segment_after_sample", 32'(want.seg_after),
                                32'(m_axis_tdata[23:17]));
                    check_field("jump_width", 32'(want.jump_width), 32'(m_axis_tdata[24]));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(0, 13);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL can_exact_bit_timing_search_core");
            $finish;
        end
    end

    initial begin
        int unsigned clk_hz;

        // default clock after reset: edges of the field and known exact fits
        queue_bitrate(0);
        queue_bitrate(1);
        queue_bitrate(80000000);
        queue_bitrate(3200000);
        queue_bitrate(10000000);
        queue_bitrate(1000000);
        queue_bitrate(500000);
        queue_bitrate(250000);
        queue_bitrate(125000);
        queue_bitrate(33333);
        queue_bitrate(10000);
        queue_bitrate(6400);
        queue_bitrate(5000);
        queue_bitrate(3125);
        queue_bitrate(2000);
        queue_bitrate('h4000000);
        queue_bitrate('h2AAAAAA);
        queue_bitrate('h1555555);
        queue_bitrate(3200001);
        queue_random(32'(CLOCK_RESET), 250);

        queue_clock(200000000);
        queue_bitrate(8000000);
        queue_random(200000000, 150);

        // largest prescaler at the top count
        queue_clock(102300000);
        queue_bitrate(4000);
        queue_bitrate(3996);
        queue_random(102300000, 100);

        queue_clock(1);
        queue_bitrate(1);
        queue_bitrate(2);
        queue_random(1, 10);

        queue_clock(0);
        queue_bitrate(1);
        queue_bitrate(1000000);
        queue_random(0, 10);

        queue_clock(40000000);
        queue_random(40000000, 120);
        queue_clock(16000000);
        queue_random(16000000, 80);
        for (int p = 0; p < 3; p++) begin
            clk_hz = $urandom_range(1, 200000000);
            queue_clock(clk_hz);
            queue_random(clk_hz, 60);
        end

        queue_clock(32'(CLOCK_RESET));
        queue_random(32'(CLOCK_RESET), 150);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid || i_cfg_valid ||
               expected_timings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        if (expected_timings.size() != 0) begin
            $error("%0d results never arrived", expected_timings.size());
            failures++;
        end
        if (failures == 0) begin
            $display("PASS can_exact_bit_timing_search_core");
        end else begin
            $display("FAIL can_exact_bit_timing_search_core");
        end
        $finish;
    end

endmodule
